/* hw/rtl/mpva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpva_pkg
// Shared types and constants for the MIDI parser and voice allocator.
// ----------------------------------------------------------------------------
package mpva_pkg;

    localparam int VOICE_COUNT_DEF = 16;

    localparam int MIDI_W     = 8;
    localparam int DATA7_W    = 7;
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int MASK_W     = 16;
    localparam int PSLOT_W    = 4;
    localparam int VALUE_W    = 14;
    localparam int OUT_DATA_W = 48;

    // Status byte high nibbles
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CTRL     = 4'hB;
    localparam logic [3:0] STATUS_BEND     = 4'hE;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_OFF  = 3'd1,
        CMD_ON   = 3'd2,
        CMD_CTRL = 3'd3,
        CMD_BEND = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_START   = 3'd1,
        KIND_DROP    = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_CTRL    = 3'd4,
        KIND_BEND    = 3'd5
    } kind_t;

    localparam int CTRL_COUNT = 12;
    localparam logic [6:0] CTRL_NUMBERS [CTRL_COUNT] = '{
        7'd1, 7'd3, 7'd9, 7'd14, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23
    };

    typedef struct packed {
        logic                 hit;
        logic [PSLOT_W-1:0]   slot;
    } ctrl_hit_t;

    // Controller number to parameter slot
    function automatic ctrl_hit_t ctrl_lookup(input logic [DATA7_W-1:0] num);
        ctrl_hit_t r;
        r.hit  = 1'b0;
        r.slot = '0;
        for (int k = 0; k < CTRL_COUNT; k++)
        begin
            if (CTRL_NUMBERS[k] == num)
            begin
                r.hit  = 1'b1;
                r.slot = PSLOT_W'(k);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/midi_parser_voice_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_parser_voice_allocator
// MIDI byte parser with a polyphonic voice allocator: one result beat per
// input byte.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata / tuser, low bit first)
// --------  ---  -----------------------------------------------------------
// s_axis    in   tdata: midi_byte[7:0]
// m_axis    out  tdata: voice_slot[3:0], release_mask[19:4], note_number[26:20],
//                       param_slot[30:27], event_value[44:31], zero pad [47:45]
//                tuser: event_kind[2:0]
//
// Sequencing: a status byte, a first data byte, a control change or a pitch
// bend goes from the idle state straight to the done state (accept, then
// result). A note on walks the voice flags one voice per cycle until it finds
// a free one, and drops the note when every voice is busy. A release walks the
// note RAM one voice per cycle through its registered read port. The single
// per-voice compare sets this pace.
// Reset: rst_n clears the parser state and all voice flags; the note RAM is
// not cleared (a note is only read for an active voice).
// Stalls: the result sits in an output register, so the next byte is taken
// while it waits; a later result waits in the done state until it drains.
// ----------------------------------------------------------------------------
module midi_parser_voice_allocator #(
    parameter int VOICE_COUNT = mpva_pkg::VOICE_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mpva_pkg::MIDI_W-1:0]       s_axis_tdata,   // midi_byte[7:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mpva_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // slot, mask, note, pslot, value
    output logic [mpva_pkg::KIND_W-1:0]       m_axis_tuser    // event_kind[2:0]
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);
    localparam int PAD_W = mpva_pkg::OUT_DATA_W - mpva_pkg::SLOT_W - mpva_pkg::MASK_W
                         - mpva_pkg::DATA7_W - mpva_pkg::PSLOT_W - mpva_pkg::VALUE_W;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ALLOC   = 4'b0010,
        ST_RELEASE = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Parser state
    mpva_pkg::cmd_t                  cmd_reg, cmd_next;
    logic                            have_first_reg, have_first_next;
    logic [mpva_pkg::DATA7_W-1:0]    first_reg, first_next;

    // Voice flags and scan
    logic [VOICE_COUNT-1:0]          active_reg, active_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]                pend_idx_reg, pend_idx_next;

    // Result being built
    mpva_pkg::kind_t                 res_kind_reg, res_kind_next;
    logic [mpva_pkg::SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [mpva_pkg::MASK_W-1:0]     res_mask_reg, res_mask_next;
    logic [mpva_pkg::DATA7_W-1:0]    res_note_reg, res_note_next;
    logic [mpva_pkg::PSLOT_W-1:0]    res_pslot_reg, res_pslot_next;
    logic [mpva_pkg::VALUE_W-1:0]    res_value_reg, res_value_next;

    // Output register
    logic                            out_vld_reg, out_vld_next;
    mpva_pkg::kind_t                 out_kind_reg;
    logic [mpva_pkg::SLOT_W-1:0]     out_slot_reg;
    logic [mpva_pkg::MASK_W-1:0]     out_mask_reg;
    logic [mpva_pkg::DATA7_W-1:0]    out_note_reg;
    logic [mpva_pkg::PSLOT_W-1:0]    out_pslot_reg;
    logic [mpva_pkg::VALUE_W-1:0]    out_value_reg;
    logic                            out_load;

    // Note RAM
    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    logic [IDX_W-1:0]                scan_idx;
    logic [mpva_pkg::DATA7_W-1:0]    ram_rdata;

    logic                            in_fire;
    logic [mpva_pkg::DATA7_W-1:0]    data7;
    mpva_pkg::ctrl_hit_t             ctrl_hit;

    assign scan_idx = cnt_reg[IDX_W-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign data7    = s_axis_tdata[mpva_pkg::DATA7_W-1:0];
    assign ctrl_hit = mpva_pkg::ctrl_lookup(first_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_vld_reg || m_axis_tready);

    mpva_ram #(
        .DATA_W (mpva_pkg::DATA7_W),
        .DEPTH  (VOICE_COUNT)
    ) u_note_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (first_reg),
        .raddr  (scan_idx),
        .rdata  (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        have_first_next = have_first_reg;
        first_next      = first_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        pend_vld_next   = 1'b0;
        pend_idx_next   = pend_idx_reg;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_mask_next   = res_mask_reg;
        res_note_next   = res_note_reg;
        res_pslot_next  = res_pslot_reg;
        res_value_next  = res_value_reg;
        ram_we          = 1'b0;
        ram_waddr       = scan_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_kind_next  = mpva_pkg::KIND_NONE;
                    res_slot_next  = '0;
                    res_mask_next  = '0;
                    res_note_next  = '0;
                    res_pslot_next = '0;
                    res_value_next = '0;
                    cnt_next       = '0;
                    state_next     = ST_DONE;
                    if (s_axis_tdata[mpva_pkg::MIDI_W-1])
                    begin
                        // Status byte: unknown ones leave the parser state alone
                        case (s_axis_tdata[7:4])
                            mpva_pkg::STATUS_NOTE_OFF:
                            begin
                                cmd_next        = mpva_pkg::CMD_OFF;
                                have_first_next = 1'b0;
                            end
                            mpva_pkg::STATUS_NOTE_ON:
                            begin
                                cmd_next        = mpva_pkg::CMD_ON;
                                have_first_next = 1'b0;
                            end
                            mpva_pkg::STATUS_CTRL:
                            begin
                                cmd_next        = mpva_pkg::CMD_CTRL;
                                have_first_next = 1'b0;
                            end
                            mpva_pkg::STATUS_BEND:
                            begin
                                cmd_next        = mpva_pkg::CMD_BEND;
                                have_first_next = 1'b0;
                            end
                            default:
                            begin
                                cmd_next = cmd_reg;
                            end
                        endcase
                    end
                    else if (cmd_reg != mpva_pkg::CMD_NONE)
                    begin
                        if (!have_first_reg)
                        begin
                            first_next      = data7;
                            have_first_next = 1'b1;
                        end
                        else
                        begin
                            have_first_next = 1'b0;
                            case (cmd_reg)
                                mpva_pkg::CMD_ON,
                                mpva_pkg::CMD_OFF:
                                begin
                                    res_note_next = first_reg;
                                    if (cmd_reg == mpva_pkg::CMD_ON && data7 != '0)
                                    begin
                                        state_next = ST_ALLOC;
                                    end
                                    else
                                    begin
                                        res_kind_next = mpva_pkg::KIND_RELEASE;
                                        state_next    = ST_RELEASE;
                                    end
                                end
                                mpva_pkg::CMD_CTRL:
                                begin
                                    if (ctrl_hit.hit)
                                    begin
                                        res_kind_next  = mpva_pkg::KIND_CTRL;
                                        res_pslot_next = ctrl_hit.slot;
                                        res_value_next = mpva_pkg::VALUE_W'(data7);
                                    end
                                end
                                mpva_pkg::CMD_BEND:
                                begin
                                    res_kind_next  = mpva_pkg::KIND_BEND;
                                    res_value_next = {data7, first_reg};
                                end
                                default:
                                begin
                                    res_kind_next = mpva_pkg::KIND_NONE;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_ALLOC:
            begin
                // one voice flag checked per cycle, lowest index first
                if (cnt_reg == CNT_W'(VOICE_COUNT))
                begin
                    res_kind_next = mpva_pkg::KIND_DROP;
                    state_next    = ST_DONE;
                end
                else if (!active_reg[scan_idx])
                begin
                    active_next[scan_idx] = 1'b1;
                    ram_we                = 1'b1;
                    res_kind_next         = mpva_pkg::KIND_START;
                    res_slot_next         = mpva_pkg::SLOT_W'(scan_idx);
                    state_next            = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_RELEASE:
            begin
                // read issued for cnt, compare on the voice read last cycle
                if (pend_vld_reg && active_reg[pend_idx_reg] && ram_rdata == first_reg)
                begin
                    active_next[pend_idx_reg] = 1'b0;
                    for (int k = 0; k < mpva_pkg::MASK_W; k++)
                    begin
                        if (k < VOICE_COUNT && int'(pend_idx_reg) == k)
                        begin
                            res_mask_next[k] = 1'b1;
                        end
                    end
                end
                if (cnt_reg == CNT_W'(VOICE_COUNT))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = scan_idx;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= mpva_pkg::CMD_NONE;
            have_first_reg <= 1'b0;
            first_reg      <= '0;
            active_reg     <= '0;
            cnt_reg        <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            have_first_reg <= have_first_next;
            first_reg      <= first_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        res_kind_reg   <= res_kind_next;
        res_slot_reg   <= res_slot_next;
        res_mask_reg   <= res_mask_next;
        res_note_reg   <= res_note_next;
        res_pslot_reg  <= res_pslot_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_slot_reg  <= res_slot_reg;
            out_mask_reg  <= res_mask_reg;
            out_note_reg  <= res_note_reg;
            out_pslot_reg <= res_pslot_reg;
            out_value_reg <= res_value_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_value_reg, out_pslot_reg, out_note_reg,
                            out_mask_reg, out_slot_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("byte accepted but sequencer stayed idle");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC || state_reg == ST_RELEASE) |-> cnt_reg <= CNT_W'(VOICE_COUNT))
        else $error("voice scan counter ran past the voice count");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= mpva_pkg::KIND_BEND)
        else $error("event kind out of range");

    a_mask_only_release: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != mpva_pkg::KIND_RELEASE)
        |-> m_axis_tdata[19:4] == '0)
        else $error("release mask set on a non-release event");

endmodule

/* hw/rtl/mpva_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpva_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpva_ram #(
    parameter int DATA_W = 7,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
